// ----- rtl/lpf_pkg.sv -----
// Shared types and constants for the largest prime factor block.
// Used by lpf_div, lpf_datapath, lpf_ctrl and largest_prime_factor; depends on nothing.

package lpf_pkg;

  localparam int unsigned ValueWidthDefault = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP,
    ST_DIV,
    ST_WAIT,
    ST_FINAL
  } lpf_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic shift;
    logic div_start;
    logic step;
    logic out_load;
  } lpf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rem_le_one;
    logic rem_even;
    logic div_done;
    logic cand_le_q;
  } lpf_sts_t;

endpackage

// ----- rtl/lpf_div.sv -----
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Depends on lpf_pkg for its default width; used by lpf_datapath.

module lpf_div #(
  parameter int unsigned VALUE_WIDTH = lpf_pkg::ValueWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] quotient_o,
  output logic [VALUE_WIDTH-1:0] remainder_o
);

  localparam int unsigned CntW = $clog2(VALUE_WIDTH);
  localparam logic [CntW-1:0] CntLast = CntW'(VALUE_WIDTH - 1);

  logic                   busy_q;
  logic                   done_q;
  logic [CntW-1:0]        cnt_q;
  logic [VALUE_WIDTH-1:0] quo_q;
  logic [VALUE_WIDTH-1:0] rem_q;

  logic [VALUE_WIDTH:0]   trial;
  logic                   fits;
  logic [VALUE_WIDTH-1:0] rem_d;

  // The dividend shifts out of the top of quo_q while quotient bits enter at the bottom.
  assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign fits  = trial >= {1'b0, divisor_i};
  assign rem_d = fits ? VALUE_WIDTH'(trial - {1'b0, divisor_i}) : trial[VALUE_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntLast;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ----- rtl/lpf_datapath.sv -----
// Datapath: magnitude logic, cofactor, trial divisor, best factor and result registers.
// Depends on lpf_pkg and lpf_div.

module lpf_datapath #(
  parameter int unsigned VALUE_WIDTH = lpf_pkg::ValueWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lpf_pkg::lpf_cmd_t             cmd_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output lpf_pkg::lpf_sts_t             sts_o,
  output logic [VALUE_WIDTH-1:0]        largest_factor_o
);

  logic [VALUE_WIDTH-1:0] rem_q;
  logic [VALUE_WIDTH-1:0] cand_q;
  logic [VALUE_WIDTH-1:0] best_q;
  logic [VALUE_WIDTH-1:0] res_q;

  logic [VALUE_WIDTH-1:0] mag;
  logic [VALUE_WIDTH-1:0] quo;
  logic [VALUE_WIDTH-1:0] div_rem;
  logic                   div_done;

  // The most negative value wraps to its correct unsigned magnitude.
  assign mag = value_i[VALUE_WIDTH-1] ? (~value_i + VALUE_WIDTH'(1)) : value_i;

  lpf_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rem_q),
    .divisor_i  (cand_q),
    .done_o     (div_done),
    .quotient_o (quo),
    .remainder_o(div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      cand_q <= '0;
      best_q <= '0;
      res_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        rem_q  <= mag;
        cand_q <= VALUE_WIDTH'(3);
        best_q <= (mag <= VALUE_WIDTH'(1)) ? mag : '0;
      end else if (cmd_i.shift) begin
        rem_q  <= rem_q >> 1;
        best_q <= VALUE_WIDTH'(2);
      end else if (cmd_i.step) begin
        if (div_rem == '0) begin
          best_q <= cand_q;
          rem_q  <= quo;
        end else begin
          cand_q <= cand_q + VALUE_WIDTH'(2);
        end
      end
      // Whatever cofactor is left above one is prime.
      if (cmd_i.out_load) begin
        res_q <= (rem_q > VALUE_WIDTH'(1) && rem_q > best_q) ? rem_q : best_q;
      end
    end
  end

  assign sts_o.rem_le_one = rem_q <= VALUE_WIDTH'(1);
  assign sts_o.rem_even   = ~rem_q[0];
  assign sts_o.div_done   = div_done;
  assign sts_o.cand_le_q  = cand_q <= quo;

  assign largest_factor_o = res_q;

endmodule

// ----- rtl/lpf_ctrl.sv -----
// Controller state machine and output word handshake.
// Depends on lpf_pkg.

module lpf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  lpf_pkg::lpf_sts_t sts_i,
  output lpf_pkg::lpf_cmd_t cmd_o
);

  lpf_pkg::lpf_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lpf_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lpf_pkg::ST_STRIP;
      end
      lpf_pkg::ST_STRIP: begin
        if (sts_i.rem_le_one) state_d = lpf_pkg::ST_FINAL;
        else if (!sts_i.rem_even) state_d = lpf_pkg::ST_DIV;
      end
      lpf_pkg::ST_DIV: begin
        state_d = lpf_pkg::ST_WAIT;
      end
      lpf_pkg::ST_WAIT: begin
        if (sts_i.div_done) begin
          state_d = sts_i.cand_le_q ? lpf_pkg::ST_DIV : lpf_pkg::ST_FINAL;
        end
      end
      lpf_pkg::ST_FINAL: begin
        if (slot_free) state_d = lpf_pkg::ST_IDLE;
      end
      default: state_d = lpf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      lpf_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      lpf_pkg::ST_STRIP: begin
        cmd_o.shift = ~sts_i.rem_le_one & sts_i.rem_even;
      end
      lpf_pkg::ST_DIV: begin
        cmd_o.div_start = 1'b1;
      end
      lpf_pkg::ST_WAIT: begin
        cmd_o.step = sts_i.div_done & sts_i.cand_le_q;
      end
      lpf_pkg::ST_FINAL: begin
        cmd_o.out_load = slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A result word is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> slot_free)
    else $error("result register overwritten while stalled");

  // The divider reports completion only while the controller waits for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == lpf_pkg::ST_WAIT))
    else $error("divider finished outside the wait state");

  // A step of the trial loop is always followed by a new division.
  a_step_then_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |=> cmd_o.div_start)
    else $error("trial step not followed by a division");

endmodule

// ----- rtl/largest_prime_factor.sv -----
// Largest prime factor of the magnitude of a signed word, found by trial division.
// Top level; depends on lpf_pkg, lpf_ctrl and lpf_datapath (which holds lpf_div).
//
// One word is factored at a time. Once it is accepted, each factor of two is shifted out
// in turn, and each odd trial divisor runs a full division in the bit-serial divider
// that yields one quotient bit per cycle. Odd divisors run up to the square root of
// the remaining cofactor, so a large prime input tries every odd divisor up to its
// square root. The result sits in an output register, so the next word can be accepted
// while it waits. Zero gives 0, plus or minus one gives 1, and the most negative value
// gives 2.

module largest_prime_factor #(
  parameter int unsigned VALUE_WIDTH = lpf_pkg::ValueWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [VALUE_WIDTH-1:0]        largest_factor_o
);

  lpf_pkg::lpf_cmd_t cmd;
  lpf_pkg::lpf_sts_t sts;

  lpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lpf_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .value_i         (value_i),
    .sts_o           (sts),
    .largest_factor_o(largest_factor_o)
  );

endmodule

// ----- bench/largest_prime_factor_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for largest_prime_factor: directed and random signed words.
// A scoreboard class predicts each largest prime factor by trial division and checks
// the results in order. Depends on lpf_pkg and the largest_prime_factor RTL.

module largest_prime_factor_tb;

  localparam int unsigned W = lpf_pkg::ValueWidthDefault;
  localparam int unsigned NumRandom = 76;
  localparam int unsigned HoldCycles = 40000;
  localparam int unsigned IdleLimit = 4000000;
  localparam int unsigned DrainCycles = 100;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic signed [W-1:0]   value_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [W-1:0]          largest_factor_o;

  largest_prime_factor #(
    .VALUE_WIDTH(W)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .largest_factor_o(largest_factor_o)
  );

  class FactorScoreboard;
    logic [W-1:0] factor_q[$];
    int unsigned  mismatches;
    int unsigned  words_in;
    int unsigned  results_out;

    function new();
      mismatches  = 0;
      words_in    = 0;
      results_out = 0;
    endfunction

    // Magnitude as an unsigned number, so the most negative word maps to 2^(W-1).
    function logic [W-1:0] largest_prime_of(logic [W-1:0] raw);
      logic [W-1:0] rest;
      logic [W-1:0] cand;
      logic [W-1:0] best;
      rest = raw[W-1] ? (~raw + 1'b1) : raw;
      if (rest <= 1) return rest;
      best = '0;
      while (rest[0] == 1'b0) begin
        best = W'(2);
        rest = rest >> 1;
      end
      cand = W'(3);
      while (cand <= rest / cand) begin
        if (rest % cand == 0) begin
          best = cand;
          rest = rest / cand;
        end else begin
          cand = cand + W'(2);
        end
      end
      if (rest > 1 && rest > best) best = rest;
      return best;
    endfunction

    function void note_word(logic [W-1:0] word);
      words_in++;
      factor_q.push_back(largest_prime_of(word));
    endfunction

    function void check_result(logic [W-1:0] got);
      logic [W-1:0] want;
      results_out++;
      if (factor_q.size() == 0) begin
        mismatches++;
        $error("largest_factor: no word outstanding, got %0d", got);
        return;
      end
      want = factor_q.pop_front();
      if (got !== want) begin
        mismatches++;
        $error("largest_factor: expected %0d, got %0d", want, got);
      end
    endfunction

    function int unsigned pending();
      return factor_q.size();
    endfunction
  endclass

  FactorScoreboard sb;
  bit              hold_req;
  int unsigned     burst_left;
  int unsigned     idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Scoreboard updates and the watchdog, all on the rising edge.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) sb.note_word(value_i);
      if (out_valid_o && !out_stall_i) sb.check_result(largest_factor_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: switches between free flow, random stalls and a periodic pattern,
  // and honors one long hold-off while the sender keeps offering.
  initial begin : receiver
    int unsigned mode;
    int unsigned mode_left;
    int unsigned tick;
    bit          hold_done;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    hold_done = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      tick++;
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 200);
        end
        mode_left--;
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 1) == 1);
          default: out_stall_i <= (tick % 4 != 0);
        endcase
      end
    end
  end

  // Offers one word, with a random gap first once the current burst is used up.
  task automatic offer_word(input logic [W-1:0] word);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 20);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      value_i    <= $urandom;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                              : $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    value_i    <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Mostly words built from small primes, so that trial division ends quickly,
  // with a few plain small numbers and the trivial magnitudes mixed in.
  function automatic logic [W-1:0] random_word();
    int unsigned     primes[11] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};
    longint unsigned mag;
    int unsigned     sel;
    int unsigned     p;
    int unsigned     n;
    logic [W-1:0]    word;
    sel = $urandom_range(0, 99);
    if (sel < 4) begin
      mag = $urandom_range(0, 1);
    end else if (sel < 12) begin
      mag = $urandom_range(2, 1 << 18);
    end else begin
      mag = $urandom_range(1, 16383);
      n   = $urandom_range(0, 10);
      repeat (n) begin
        p = primes[$urandom_range(0, 10)];
        if (mag * p < 64'h8000_0000) mag = mag * p;
      end
    end
    word = mag[W-1:0];
    if ($urandom_range(0, 1) == 1) word = -word;
    return word;
  endfunction

  initial begin : stimulus
    logic [W-1:0] directed[$];
    sb          = new();
    hold_req    = 1'b0;
    burst_left  = 0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    rst_ni      = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero, both units, powers of two, the most negative word, the largest
    // positive word (a prime), alternating bit patterns, squares and primes.
    directed = '{32'd0, 32'd1, -32'sd1, 32'd2, -32'sd2, 32'd3, 32'd4,
                 32'h4000_0000, 32'h8000_0000, 32'h7FFF_FFFE, 32'h7FFF_FFFF,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'd9, 32'd25, 32'd6, 32'd15,
                 32'd3072, 32'd97, -32'sd97, 32'd12, 32'd81, 32'd1369, -32'sd4};
    foreach (directed[i]) offer_word(directed[i]);

    // The receiver holds off for a long stretch while words keep coming.
    hold_req = 1'b1;
    repeat (NumRandom) offer_word(random_word());
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Factored %0d words (directed extremes, units, powers of two and random",
             sb.words_in);
    $display("small-prime products) and checked %0d results.", sb.results_out);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
